@@ src/assert_macros.svh @@
// Assertion helpers shared by the top level and the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle implication failed");

`endif

@@ src/trdf_pkg.sv @@
package trdf_pkg;

   // Fixed field widths of the request and response items.
   localparam int unsigned NUMBER_W    = 64;
   localparam int unsigned FACTOR_W    = 64;
   localparam int unsigned INDEX_W     = 6;
   localparam int unsigned RSP_PAD_W   = 2;
   localparam int unsigned RSP_TDATA_W = FACTOR_W + INDEX_W + RSP_PAD_W;

   // The first trial divisor.
   localparam int unsigned TRIAL_FIRST = 2;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT_DIV,
      ST_EMIT_REM,
      ST_EMIT_NONE
   } fsm_state_type;

   // Status from the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
      logic exact;
   } div_stat_type;

   // Commands to the trial divisor sequence.
   typedef struct packed {
      logic init;
      logic advance;
   } trial_ctl_type;

endpackage

@@ src/trial_division_factorizer_unit.sv @@
// Each trial divisor takes a check step, DATA_WIDTH bit-serial divider steps and a done step;
// each factor found adds one more division and an emit step. A request runs about
// max(second-largest prime, sqrt(largest prime)) trials, at most 2^(DATA_WIDTH/2);
// response stalls on rsp_tready lengthen it.
// Throughput: one request at a time; the next is taken once the last response is registered.
// Reset: synchronous, active high; clears the sequencer, the divider control and the output valid.
`include "assert_macros.svh"

module trial_division_factorizer_unit import trdf_pkg::*; #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [NUMBER_W-1:0]    req_tdata,   // [63:0] number
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [63:0] factor, [69:64] factor_index, [71:70] zero
   output logic                   rsp_tuser,   // [0] no_factors
   output logic                   rsp_tlast
);

   localparam int unsigned DIV_W = (DATA_WIDTH + 1) / 2 + 2;
   localparam int unsigned SQ_W  = DATA_WIDTH + 2;

   fsm_state_type         state_ff, state_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FACTOR_W-1:0]   rsp_factor_ff, rsp_factor_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                  rsp_none_ff, rsp_none_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  load_out;
   logic                  div_start;
   div_stat_type          div_stat;
   logic [DATA_WIDTH-1:0] div_quo;
   trial_ctl_type         trial_ctl;
   logic [DIV_W-1:0]      trial_div;
   logic                  trial_in_range;

   trdf_divider #(
      .DVD_W (DATA_WIDTH),
      .DVS_W (DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rem_ff),
      .divisor  (trial_div),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   trdf_trial_seq #(
      .REM_W (DATA_WIDTH),
      .DIV_W (DIV_W),
      .SQ_W  (SQ_W)
   ) u_trial_seq (
      .clock    (clock),
      .ctl      (trial_ctl),
      .rem      (rem_ff),
      .divisor  (trial_div),
      .in_range (trial_in_range)
   );

   // The output register can take a new response when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer: next state, remainder update and response loading.
   always_comb begin
      state_in          = state_ff;
      rem_in            = rem_ff;
      idx_in            = idx_ff;
      div_start         = 1'b0;
      trial_ctl.init    = 1'b0;
      trial_ctl.advance = 1'b0;
      load_out          = 1'b0;
      rsp_factor_in     = rsp_factor_ff;
      rsp_index_in      = rsp_index_ff;
      rsp_none_in       = rsp_none_ff;
      rsp_last_in       = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rem_in         = req_tdata[DATA_WIDTH-1:0];
               idx_in         = '0;
               trial_ctl.init = 1'b1;
               if (req_tdata[DATA_WIDTH-1:1] == '0) begin
                  state_in = ST_EMIT_NONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            priority if (rem_ff == DATA_WIDTH'(1)) begin
               state_in = ST_IDLE;
            end else if (trial_in_range) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_EMIT_REM;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               if (div_stat.exact) begin
                  state_in = ST_EMIT_DIV;
               end else begin
                  trial_ctl.advance = 1'b1;
                  state_in          = ST_CHECK;
               end
            end
         end
         ST_EMIT_DIV: begin
            if (out_free) begin
               load_out      = 1'b1;
               rsp_factor_in = FACTOR_W'(trial_div);
               rsp_index_in  = idx_ff;
               rsp_none_in   = 1'b0;
               rsp_last_in   = (div_quo == DATA_WIDTH'(1));
               rem_in        = div_quo;
               idx_in        = idx_ff + INDEX_W'(1);
               state_in      = ST_CHECK;
            end
         end
         ST_EMIT_REM: begin
            if (out_free) begin
               load_out      = 1'b1;
               rsp_factor_in = FACTOR_W'(rem_ff);
               rsp_index_in  = idx_ff;
               rsp_none_in   = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_NONE: begin
            if (out_free) begin
               load_out      = 1'b1;
               rsp_factor_in = '0;
               rsp_index_in  = '0;
               rsp_none_in   = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid follows loads and drains.
   always_comb begin
      priority if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_none_ff   <= rsp_none_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_index_ff, rsp_factor_ff};
   assign rsp_tuser  = rsp_none_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_IMPLIES(a_divide_has_divider, clock, reset, state_ff == ST_DIVIDE, div_stat.busy || div_stat.done)
   `ASSERT_IMPLIES(a_rem_nonzero, clock, reset, state_ff == ST_CHECK || state_ff == ST_DIVIDE, rem_ff != '0)
   `ASSERT_NEXT(a_emit_loads_output, clock, reset, load_out, rsp_valid_ff)

endmodule

@@ src/trdf_divider.sv @@
`include "assert_macros.svh"

// Restoring divider that retires one quotient bit per cycle.
module trdf_divider import trdf_pkg::*; #(
   parameter int unsigned DVD_W = 64,
   parameter int unsigned DVS_W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output div_stat_type     stat,
   output logic [DVD_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] part_ff, part_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // One step: bring down the next dividend bit and try to subtract.
   assign trial = {part_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = !diff[DVS_W];

   // Next-state logic for the shift registers and the bit counter.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      part_in = part_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         part_in = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         part_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Data shift registers.
   always_ff @(posedge clock) begin
      part_ff <= part_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign stat.busy  = busy_ff;
   assign stat.done  = done_ff;
   assign stat.exact = (part_ff == '0);
   assign quotient   = quo_ff;

   `ASSERT_IMPLIES(a_start_when_idle, clock, reset, start, !busy_ff)
   `ASSERT_NEXT(a_done_is_pulse, clock, reset, done_ff, !done_ff)
   `ASSERT_IMPLIES(a_busy_count_live, clock, reset, busy_ff, cnt_ff != '0)

endmodule

@@ src/trdf_trial_seq.sv @@
// Trial divisor and its square, stepped together so no multiplier is needed.
module trdf_trial_seq import trdf_pkg::*; #(
   parameter int unsigned REM_W = 64,
   parameter int unsigned DIV_W = 34,
   parameter int unsigned SQ_W  = 66
) (
   input  logic             clock,
   input  trial_ctl_type    ctl,
   input  logic [REM_W-1:0] rem,
   output logic [DIV_W-1:0] divisor,
   output logic             in_range
);

   logic [DIV_W-1:0] div_ff, div_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;

   // (d + 1)^2 = d^2 + 2d + 1.
   always_comb begin
      div_in = div_ff;
      sq_in  = sq_ff;
      if (ctl.init) begin
         div_in = DIV_W'(TRIAL_FIRST);
         sq_in  = SQ_W'(TRIAL_FIRST * TRIAL_FIRST);
      end else if (ctl.advance) begin
         div_in = div_ff + DIV_W'(1);
         sq_in  = sq_ff + {{(SQ_W-DIV_W-1){1'b0}}, div_ff, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      sq_ff  <= sq_in;
   end

   // Keep dividing while the divisor squared does not exceed the remainder.
   assign in_range = (sq_ff <= {{(SQ_W-REM_W){1'b0}}, rem});
   assign divisor  = div_ff;

endmodule

@@ verif/trial_division_factorizer_unit_test.sv @@
module trial_division_factorizer_unit_test;
   import trdf_pkg::*;

   // One expected response: a prime factor and its place in the run.
   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic [INDEX_W-1:0]  position;
      logic                no_factors;
      logic                last;
   } factor_rsp_type;

   localparam longint unsigned ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int              SETTLE_CYC = 200;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [NUMBER_W-1:0]    req_tdata;     // [63:0] number
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;     // [63:0] factor, [69:64] factor_index, [71:70] zero
   logic                   rsp_tuser;     // [0] no_factors
   logic                   rsp_tlast;

   factor_rsp_type pending_factors[$];
   int             error_count = 0;
   bit             idle_enable = 1'b1;

   trial_division_factorizer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Trial division at full width: the divisor is kept below 2^32 so that its
   // square never wraps. Appends the expected responses for one request.
   task automatic predict_factors(input longint unsigned number);
      longint unsigned remaining;
      longint unsigned divisor;
      longint unsigned primes[$];
      factor_rsp_type  rsp;
      begin
         if (number < 2) begin
            rsp = '{factor: '0, position: '0, no_factors: 1'b1, last: 1'b1};
            pending_factors.push_back(rsp);
         end else begin
            remaining = number;
            divisor   = TRIAL_FIRST;
            while (divisor <= 64'hFFFF_FFFF && divisor * divisor <= remaining) begin
               while (remaining % divisor == 0) begin
                  primes.push_back(divisor);
                  remaining = remaining / divisor;
               end
               divisor++;
            end
            if (remaining > 1)
               primes.push_back(remaining);
            foreach (primes[i]) begin
               rsp.factor     = primes[i];
               rsp.position   = i[INDEX_W-1:0];
               rsp.no_factors = 1'b0;
               rsp.last       = (i == primes.size() - 1);
               pending_factors.push_back(rsp);
            end
         end
      end
   endtask

   // Sends one request, with an occasional gap before it while idling is on.
   task automatic send_number(input longint unsigned number);
      begin
         if (idle_enable && $urandom_range(0, 2) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         predict_factors(number);
         req_tvalid <= 1'b1;
         req_tdata  <= number;
         do @(posedge clock); while (!req_tready);
      end
   endtask

   // Builds a number from small random factors, so that trial division ends
   // quickly. Some products are filled up until the next factor would overflow.
   function automatic longint unsigned random_product();
      longint unsigned product;
      int              count;
      int              max_factor;
      int              f;
      begin
         product    = 1;
         count      = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 20);
         max_factor = ($urandom_range(0, 7) == 0) ? 256 : 48;
         for (int i = 0; i < count; i++) begin
            f = $urandom_range(2, max_factor);
            if (product > ALL_ONES / f)
               break;
            product = product * f;
         end
         if ($urandom_range(0, 15) == 0)
            product = $urandom_range(0, 1);
         return product;
      end
   endfunction

   // Response sink: ready alternates between runs and random stall bursts while idling is on.
   initial begin
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Compare every accepted response against the oldest expectation.
   always @(posedge clock) begin
      factor_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_factors.size() == 0) begin
            $error("response with no request pending: factor %0d", rsp_tdata[63:0]);
            error_count++;
         end else begin
            want = pending_factors.pop_front();
            if (rsp_tdata[63:0] !== want.factor) begin
               $error("factor: expected %0d, got %0d", want.factor, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tdata[69:64] !== want.position) begin
               $error("factor_index: expected %0d, got %0d", want.position,
                      rsp_tdata[69:64]);
               error_count++;
            end
            if (rsp_tdata[71:70] !== 2'b00) begin
               $error("pad: expected 0, got %0d", rsp_tdata[71:70]);
               error_count++;
            end
            if (rsp_tuser !== want.no_factors) begin
               $error("no_factors: expected %0d, got %0d", want.no_factors, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Zero and one carry no factors; small values give one or two factors.
   task automatic test_trivial_numbers();
      begin
         send_number(0);
         send_number(1);
         send_number(2);
         send_number(3);
         send_number(4);
         send_number(6);
      end
   endtask

   // Long runs of one prime reach the top bits and the highest factor index.
   task automatic test_prime_powers();
      begin
         send_number(64'h8000_0000_0000_0000);   // 2^63: 63 responses
         send_number(64'd12157665459056928801); // 3^40
         send_number(64'd7450580596923828125);  // 5^27
         send_number(64'd3909821048582988049);  // 7^22
         send_number(64'hC000_0000_0000_0000);   // 3 * 2^62
         send_number(64'hE000_0000_0000_0000);   // 7 * 2^61
         send_number(64'h0000_0001_0000_0000);   // 2^32
         send_number(9409);                      // square of a prime
      end
   endtask

   // A prime left over after the trial loop becomes the last factor.
   task automatic test_large_prime_factors();
      begin
         send_number(65521);
         send_number(131042);         // 2 * 65521
         send_number(1000003);
         send_number(1022117);        // 1009 * 1013
         send_number(30030);
         send_number(64'd510510 * 64'd251);
      end
   endtask

   task automatic test_random_products(input int count);
      begin
         for (int i = 0; i < count; i++)
            send_number(random_product());
      end
   endtask

   // Final stretch with neither side idling.
   task automatic test_back_to_back(input int count);
      begin
         idle_enable = 1'b0;
         test_random_products(count);
      end
   endtask

   // Run timeout.
   initial begin
      #400_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_trivial_numbers();
      test_prime_powers();
      test_large_prime_factors();
      test_random_products(65);
      test_back_to_back(15);

      // Let the last responses come in, then watch for stray ones.
      req_tvalid <= 1'b0;
      while (pending_factors.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      if (error_count == 0 && pending_factors.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/trdf_pkg.sv
src/trdf_divider.sv
src/trdf_trial_seq.sv
src/trial_division_factorizer_unit.sv
verif/trial_division_factorizer_unit_test.sv
